// ===== rtl/core/ffha_pkg.sv =====
// first-fit heap allocator: shared codes and types
// command codes, result status codes and the cell operation codes
// no dependencies
`default_nettype none

package ffha_pkg;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_SATURATED = 3'd1;
	localparam status_t ST_NOFIT     = 3'd2;
	localparam status_t ST_NOTALLOC  = 3'd3;
	localparam status_t ST_REDUNDANT = 3'd4;

	// operation broadcast along the cell row
	typedef logic [1:0] op_code_t;
	localparam op_code_t OP_NOP = 2'd0;  // hold
	localparam op_code_t OP_SET = 2'd1;  // rewrite one entry
	localparam op_code_t OP_INS = 2'd2;  // split entry, shift later ones up
	localparam op_code_t OP_MRG = 2'd3;  // absorb next entry, shift later ones down

endpackage

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_top.sv =====
// first-fit heap allocator with coalescing, top level
// sequencer walking a row of ffha_cell entries, plus the result register
// depends on ffha_pkg and ffha_cell
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   command, request_bytes, free_offset
// out      output     out_valid/out_stall grant_offset, status
//
// an allocate walks the table up to its first fit, n entries (at most MAX_BLOCKS);
// a free walks to its entry, then passes S_MNEXT and S_MPREV to merge on a hit;
// the walk reads one table entry per cycle through one registered read port,
// fetching entry i+1 while entry i is tested
// reset restores one free block of ARENA_BYTES - HEADER_BYTES
// a new command is taken while the last result still waits on out_stall
`default_nettype none

module first_fit_heap_allocator_top
	import ffha_pkg::*;
#(
	parameter int ARENA_BYTES  = 4096,
	parameter int HEADER_BYTES = 16,
	parameter int MAX_BLOCKS   = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [12:0] request_bytes,
	input  wire logic [11:0] free_offset,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [11:0] grant_offset,
	output logic      [2:0]  status
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int BW = $clog2(ARENA_BYTES + 1);
	localparam int WW = BW + 15;   // room for request plus header and loc sums

	localparam logic [WW-1:0] HDR  = WW'(HEADER_BYTES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_AWALK = 3'd1;
	localparam logic [2:0] S_FWALK = 3'd2;
	localparam logic [2:0] S_MNEXT = 3'd3;
	localparam logic [2:0] S_MPREV = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]    state_q;
	logic [12:0]   req_q;
	logic [11:0]   off_q;
	logic [CW-1:0] i_q;
	logic [WW-1:0] loc_q;
	logic          any_free_q;
	logic [CW-1:0] count_q;
	logic [11:0]   res_grant_q;
	status_t       res_status_q;
	logic          out_valid_q;
	logic [11:0]   grant_q;
	status_t       status_q;
	logic [BW-1:0] rd_b_q;        // registered read of the table
	logic          rd_u_q;
	logic [BW-1:0] hold_bytes_q;  // size of the entry being freed

	// cell row
	logic [BW-1:0] cell_bytes [MAX_BLOCKS];
	logic          cell_used  [MAX_BLOCKS];

	op_code_t      op;
	logic [IW-1:0] op_idx;
	logic          op_used;
	logic [BW-1:0] op_bytes_a;
	logic [BW-1:0] op_bytes_b;

	genvar k;
	generate
		for (k = 0; k < MAX_BLOCKS; k++) begin : g_cell
			logic [BW-1:0] lb, rb;
			logic          lu, ru;
			if (k > 0) begin : g_l
				assign lb = cell_bytes[k-1];
				assign lu = cell_used[k-1];
			end else begin : g_l0
				assign lb = '0;
				assign lu = 1'b0;
			end
			if (k < MAX_BLOCKS - 1) begin : g_r
				assign rb = cell_bytes[k+1];
				assign ru = cell_used[k+1];
			end else begin : g_r0
				assign rb = '0;
				assign ru = 1'b0;
			end
			ffha_cell #(
				.CELL_IDX   (k),
				.IW         (IW),
				.BW         (BW),
				.RESET_BYTES((k == 0) ? (ARENA_BYTES - HEADER_BYTES) : 0)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.op         (op),
				.op_idx     (op_idx),
				.op_used    (op_used),
				.op_bytes_a (op_bytes_a),
				.op_bytes_b (op_bytes_b),
				.left_bytes (lb),
				.left_used  (lu),
				.right_bytes(rb),
				.right_used (ru),
				.bytes      (cell_bytes[k]),
				.used       (cell_used[k])
			);
		end
	endgenerate

	// walk index and its neighbor below
	logic [IW-1:0] cur_i, prv_i, rd_idx;
	logic [BW-1:0] cur_b;
	logic          cur_u;
	assign cur_i = i_q[IW-1:0];
	assign prv_i = cur_i - 1'b1;
	// the read register holds entry i in the walk, entry i+1 in S_MNEXT
	// and entry i-1 in S_MPREV
	assign cur_b = rd_b_q;
	assign cur_u = rd_u_q;

	// address fetched for the next cycle
	always_comb begin
		rd_idx = '0;
		unique case (state_q) inside
			S_AWALK, S_FWALK: rd_idx = cur_i + 1'b1;
			S_MNEXT:          rd_idx = prv_i;
			default:          rd_idx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_b_q <= cell_bytes[rd_idx];
		rd_u_q <= cell_used[rd_idx];
	end

	logic [WW-1:0] sz_w, req_w, off_w;
	logic          walk_end, is_free, fits_split, fits_whole, has_next, has_prev;
	assign sz_w       = WW'(cur_b);
	assign req_w      = WW'(req_q);
	assign off_w      = WW'(off_q);
	assign walk_end   = (i_q >= count_q);
	assign is_free    = !cur_u;
	assign fits_split = is_free && (sz_w > req_w + HDR);
	assign fits_whole = is_free && (sz_w >= req_w);
	assign has_next   = ((i_q + 1'b1) < count_q) && !rd_u_q;
	assign has_prev   = (i_q != '0) && !rd_u_q;

	logic [WW-1:0] rest_w, mnext_w, mprev_w;
	assign rest_w  = sz_w - req_w - HDR;
	assign mnext_w = WW'(hold_bytes_q) + WW'(rd_b_q) + HDR;
	assign mprev_w = WW'(rd_b_q) + WW'(hold_bytes_q) + HDR;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// operation issued to the cell row this cycle
	always_comb begin
		op         = OP_NOP;
		op_idx     = cur_i;
		op_used    = 1'b0;
		op_bytes_a = cur_b;
		op_bytes_b = rest_w[BW-1:0];
		unique case (state_q)
			S_AWALK: begin
				if (!walk_end && fits_split) begin
					if (count_q < MAXC) begin
						op         = OP_INS;
						op_bytes_a = BW'(req_q);
					end else begin
						op      = OP_SET;
						op_used = 1'b1;
					end
				end else if (!walk_end && fits_whole) begin
					op      = OP_SET;
					op_used = 1'b1;
				end
			end
			S_FWALK: begin
				if (!walk_end && loc_q == off_w && cur_u) begin
					op      = OP_SET;
					op_used = 1'b0;
				end
			end
			S_MNEXT: begin
				if (has_next) begin
					op         = OP_MRG;
					op_bytes_a = mnext_w[BW-1:0];
				end
			end
			S_MPREV: begin
				if (has_prev) begin
					op         = OP_MRG;
					op_idx     = prv_i;
					op_bytes_a = mprev_w[BW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= CW'(1);
			i_q        <= '0;
			any_free_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= (command == CMD_FREE) ? S_FWALK : S_AWALK;
						i_q        <= '0;
						any_free_q <= 1'b0;
					end
				end
				S_AWALK: begin
					if (walk_end || fits_whole || fits_split) begin
						state_q <= S_DONE;
						if (!walk_end && fits_split && count_q < MAXC)
							count_q <= count_q + 1'b1;
					end else begin
						any_free_q <= any_free_q | is_free;
						i_q        <= i_q + 1'b1;
					end
				end
				S_FWALK: begin
					if (walk_end) begin
						state_q <= S_DONE;
					end else if (loc_q == off_w) begin
						state_q <= cur_u ? S_MNEXT : S_DONE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_MNEXT: begin
					state_q <= S_MPREV;
					if (has_next)
						count_q <= count_q - 1'b1;
				end
				S_MPREV: begin
					state_q <= S_DONE;
					if (has_prev)
						count_q <= count_q - 1'b1;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command fields, walk offset and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q <= request_bytes;
				off_q <= free_offset;
				loc_q <= HDR;
			end
			S_AWALK: begin
				if (walk_end) begin
					res_grant_q  <= '0;
					res_status_q <= (any_free_q) ? ST_NOFIT : ST_SATURATED;
				end else if (fits_whole || fits_split) begin
					res_grant_q  <= loc_q[11:0];
					res_status_q <= ST_OK;
				end else begin
					loc_q <= loc_q + sz_w + HDR;
				end
			end
			S_FWALK: begin
				res_grant_q  <= '0;
				hold_bytes_q <= cur_b;
				if (walk_end)
					res_status_q <= ST_NOTALLOC;
				else if (loc_q == off_w)
					res_status_q <= cur_u ? ST_OK : ST_REDUNDANT;
				else
					loc_q <= loc_q + sz_w + HDR;
			end
			S_MNEXT: begin
				if (has_next)
					hold_bytes_q <= mnext_w[BW-1:0];
			end
			default: begin
			end
		endcase
	end

	// output register, one transfer per command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			grant_q  <= res_grant_q;
			status_q <= res_status_q;
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign grant_offset = grant_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// ===== rtl/core/ffha_cell.sv =====
// first-fit heap allocator: one table entry of the cell row
// holds size and used mark, takes a neighbor's entry on insert or merge
// depends on ffha_pkg
`default_nettype none

module ffha_cell
	import ffha_pkg::*;
#(
	parameter int CELL_IDX    = 0,
	parameter int IW          = 6,
	parameter int BW          = 13,
	parameter int RESET_BYTES = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire op_code_t      op,
	input  wire logic [IW-1:0] op_idx,
	input  wire logic          op_used,
	input  wire logic [BW-1:0] op_bytes_a,
	input  wire logic [BW-1:0] op_bytes_b,
	input  wire logic [BW-1:0] left_bytes,
	input  wire logic          left_used,
	input  wire logic [BW-1:0] right_bytes,
	input  wire logic          right_used,
	output logic      [BW-1:0] bytes,
	output logic               used
);

	localparam logic [IW:0] MY = (IW+1)'(CELL_IDX);

	logic [IW:0] idx_x;
	logic        is_me, is_next, is_above;
	logic [BW-1:0] bytes_d;
	logic          used_d;

	assign idx_x    = {1'b0, op_idx};
	assign is_me    = (MY == idx_x);
	assign is_next  = (MY == idx_x + 1'b1);
	assign is_above = (MY > idx_x + 1'b1);

	always_comb begin
		bytes_d = bytes;
		used_d  = used;
		case (op)
			OP_SET: begin
				if (is_me) begin
					bytes_d = op_bytes_a;
					used_d  = op_used;
				end
			end
			OP_INS: begin
				if (is_me) begin
					bytes_d = op_bytes_a;
					used_d  = 1'b1;
				end else if (is_next) begin
					bytes_d = op_bytes_b;
					used_d  = 1'b0;
				end else if (is_above) begin
					bytes_d = left_bytes;
					used_d  = left_used;
				end
			end
			OP_MRG: begin
				if (is_me) begin
					bytes_d = op_bytes_a;
					used_d  = 1'b0;
				end else if (MY > idx_x) begin
					bytes_d = right_bytes;
					used_d  = right_used;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes <= BW'(RESET_BYTES);
			used  <= 1'b0;
		end else begin
			bytes <= bytes_d;
			used  <= used_d;
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_first_fit_heap_allocator_top.sv =====
// testbench for first_fit_heap_allocator_top: directed and random allocate/free traffic
// keeps its own copy of the block table and checks every result in order
// depends on ffha_pkg and the allocator rtl
`default_nettype none

module tb_first_fit_heap_allocator_top
	import ffha_pkg::*;
();

	localparam int ARENA  = 4096;
	localparam int HDR    = 16;
	localparam int NBLK   = 64;
	localparam int WDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_ALLOC;
	logic [12:0] request_bytes = '0;
	logic [11:0] free_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [11:0] grant_offset;
	logic [2:0]  status;

	first_fit_heap_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .request_bytes(request_bytes), .free_offset(free_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.grant_offset(grant_offset), .status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the block table
	int unsigned tbl_bytes[NBLK];
	bit          tbl_used[NBLK];
	int unsigned tbl_count;

	typedef struct {
		logic [11:0] offset;
		status_t     st;
	} grant_t;

	grant_t      pending_grants[$];
	logic [11:0] live_offsets[$];   // data offsets we believe are allocated
	int          err_count = 0;
	int          idle_cycles = 0;
	bit          rx_hold = 1'b0;    // forces a long receiver hold-off
	bit          rx_random = 1'b1;
	int          rx_left = 0;       // cycles left in a random long hold

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic void table_reset();
		for (int i = 0; i < NBLK; i++) begin
			tbl_bytes[i] = 0;
			tbl_used[i] = 1'b0;
		end
		tbl_bytes[0] = ARENA - HDR;
		tbl_count = 1;
	endfunction

	function automatic void table_drop(input int unsigned idx);
		for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
			tbl_bytes[k] = tbl_bytes[k + 1];
			tbl_used[k] = tbl_used[k + 1];
		end
		tbl_count--;
	endfunction

	function automatic grant_t alloc_predict(input int unsigned req);
		grant_t      g;
		int unsigned loc;
		bit          any_free;
		loc = HDR;
		any_free = 1'b0;
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (!tbl_used[i] && tbl_bytes[i] > req + HDR) begin
				// split unless the table is full, then grant whole
				if (tbl_count < NBLK) begin
					for (int unsigned k = tbl_count; k > i + 1; k--) begin
						tbl_bytes[k] = tbl_bytes[k - 1];
						tbl_used[k] = tbl_used[k - 1];
					end
					tbl_bytes[i + 1] = tbl_bytes[i] - req - HDR;
					tbl_used[i + 1] = 1'b0;
					tbl_bytes[i] = req;
					tbl_count++;
				end
				tbl_used[i] = 1'b1;
				g.offset = loc[11:0];
				g.st = ST_OK;
				return g;
			end
			if (!tbl_used[i] && tbl_bytes[i] >= req) begin
				tbl_used[i] = 1'b1;
				g.offset = loc[11:0];
				g.st = ST_OK;
				return g;
			end
			if (!tbl_used[i])
				any_free = 1'b1;
			loc += tbl_bytes[i] + HDR;
		end
		g.offset = '0;
		g.st = any_free ? ST_NOFIT : ST_SATURATED;
		return g;
	endfunction

	function automatic grant_t free_predict(input int unsigned off);
		grant_t      g;
		int unsigned loc;
		int unsigned i;
		loc = HDR;
		g.offset = '0;
		for (i = 0; i < tbl_count; i++) begin
			if (loc == off)
				break;
			loc += tbl_bytes[i] + HDR;
		end
		if (i >= tbl_count) begin
			g.st = ST_NOTALLOC;
			return g;
		end
		if (!tbl_used[i]) begin
			g.st = ST_REDUNDANT;
			return g;
		end
		tbl_used[i] = 1'b0;
		// merge with a free successor, then a free predecessor
		if (i + 1 < tbl_count && !tbl_used[i + 1]) begin
			tbl_bytes[i] += tbl_bytes[i + 1] + HDR;
			table_drop(i + 1);
		end
		if (i > 0 && !tbl_used[i - 1]) begin
			tbl_bytes[i - 1] += tbl_bytes[i] + HDR;
			table_drop(i);
		end
		g.st = ST_OK;
		return g;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one transfer on the input channel, prediction made at acceptance
	// valid stays high after the transfer; drain() or a gap in the next call drops it
	task automatic send_cmd(input logic cmd, input logic [12:0] req, input logic [11:0] off,
			input bit gaps = 1'b1);
		grant_t g;
		int     n;
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		request_bytes <= req;
		free_offset <= off;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (cmd == CMD_ALLOC) begin
			g = alloc_predict(req);
			if (g.st == ST_OK)
				live_offsets.push_back(g.offset);
		end else begin
			g = free_predict(off);
			if (g.st == ST_OK)
				foreach (live_offsets[j])
					if (live_offsets[j] == off) begin
						live_offsets.delete(j);
						break;
					end
		end
		pending_grants.push_back(g);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (NBLK + 8) @(posedge clk);
	endtask

	// receiver stall pattern, mostly short stalls with an occasional long hold
	always @(posedge clk) begin
		if (rx_hold) begin
			out_stall <= 1'b1;
		end else if (rx_left > 0) begin
			out_stall <= 1'b1;
			rx_left <= rx_left - 1;
		end else if (rx_random) begin
			if ($urandom_range(0, 99) < 2) begin
				out_stall <= 1'b1;
				rx_left <= $urandom_range(8, 40);
			end else begin
				out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
			end
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin : chk
		grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result", int'(status), 0);
			end else begin
				want = pending_grants.pop_front();
				if (grant_offset !== want.offset)
					report_mismatch("grant_offset", int'(grant_offset), int'(want.offset));
				if (status !== want.st)
					report_mismatch("status", int'(status), int'(want.st));
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("tb_first_fit_heap_allocator_top failed");
			$finish;
		end
	end

	task automatic free_random_live();
		int j;
		if (live_offsets.size() == 0) begin
			send_cmd(CMD_FREE, 13'($urandom), 12'($urandom));
		end else begin
			j = $urandom_range(0, live_offsets.size() - 1);
			send_cmd(CMD_FREE, 13'($urandom), live_offsets[j]);
		end
	endtask

	// extremes, saturation, no fit, bad and redundant frees, coalescing
	task automatic test_directed();
		send_cmd(CMD_FREE, 13'd0, 12'd16);          // redundant free of the initial block
		send_cmd(CMD_ALLOC, 13'd4096, 12'd0);       // too large: no fit
		send_cmd(CMD_ALLOC, 13'd4080, 12'd0);       // whole arena
		send_cmd(CMD_ALLOC, 13'd0, 12'd0);          // saturated
		send_cmd(CMD_FREE, 13'h1fff, 12'd16);
		send_cmd(CMD_ALLOC, 13'd0, 12'd0);          // zero-byte split
		send_cmd(CMD_ALLOC, 13'd100, 12'hfff);
		send_cmd(CMD_ALLOC, 13'd200, 12'd0);
		send_cmd(CMD_FREE, 13'd0, 12'd20);          // inside a block: not allocated
		send_cmd(CMD_FREE, 13'd0, 12'hfff);
		send_cmd(CMD_FREE, 13'd0, 12'd0);
		send_cmd(CMD_FREE, 13'd0, 12'd32);          // middle block
		send_cmd(CMD_FREE, 13'd0, 12'd32);          // redundant
		send_cmd(CMD_FREE, 13'd0, 12'd16);          // merges forward
		send_cmd(CMD_FREE, 13'd0, 12'd148);         // merges both ways
		send_cmd(CMD_ALLOC, 13'd4064, 12'd0);       // fit with no room to split after coalescing: granted whole
		send_cmd(CMD_FREE, 13'd0, 12'd16);
		drain();
	endtask

	// fill the table to its limit so a split must grant whole
	task automatic test_table_full();
		for (int i = 0; i < NBLK + 2; i++)
			send_cmd(CMD_ALLOC, 13'd0, 12'd0);
		send_cmd(CMD_ALLOC, 13'd8, 12'd0);
		while (live_offsets.size() != 0)
			free_random_live();
		drain();
	endtask

	// receiver holds off for a long stretch while commands keep coming
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
			begin
				for (int i = 0; i < 12; i++)
					send_cmd(CMD_ALLOC, 13'($urandom_range(0, 64)), 12'd0, 1'b0);
				in_valid <= 1'b0;
			end
		join
		drain();
	endtask

	task automatic test_random(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (i % 300 == 299)
				drain();                            // sender pause until all results are in
			if (i % 500 == 250)
				rx_random = ~rx_random;             // stretches with a fast receiver
			if (r < 45)
				send_cmd(CMD_ALLOC, ($urandom_range(0, 9) == 0) ? 13'($urandom) :
					13'($urandom_range(0, 200)), 12'($urandom));
			else if (r < 88)
				free_random_live();
			else if (r < 94)
				send_cmd(CMD_FREE, 13'($urandom), 12'($urandom));
			else
				send_cmd(CMD_FREE, 13'($urandom), 12'($urandom_range(0, 255)) & 12'hff0);
		end
		rx_random = 1'b1;
	endtask

	initial begin
		table_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random(1600);
		drain();
		if (err_count == 0 && pending_grants.size() == 0)
			$display("tb_first_fit_heap_allocator_top passed");
		else
			$display("tb_first_fit_heap_allocator_top failed");
		$finish;
	end

endmodule

`default_nettype wire
